// File: rtl/frml_pkg.sv
// frml_pkg: shared types and constants for the frame rate meter and limiter
// no dependencies; imported by every module of the block

package frml_pkg;

  localparam int unsigned TS_W     = 32;
  localparam int unsigned PER_W    = 16;
  localparam int unsigned CFG_W    = 10;
  localparam int unsigned FPS_W    = 22;
  localparam int unsigned SCALE_W  = 18;

  localparam logic [CFG_W-1:0]   FRAME_PERIOD_RST = CFG_W'(16);
  localparam logic [PER_W-1:0]   PERIOD_SAT       = {PER_W{1'b1}};
  localparam logic [FPS_W-1:0]   FPS_MAX          = {FPS_W{1'b1}};
  localparam logic [SCALE_W-1:0] FPS_SCALE        = SCALE_W'(256000);

  typedef struct packed {
    logic            operation;
    logic [TS_W-1:0] timestamp_ms;
  } frml_in_t;

  typedef struct packed {
    logic [FPS_W-1:0] fps_q8;
    logic [PER_W-1:0] frame_time_ms;
    logic [CFG_W-1:0] delay_ms;
  } frml_out_t;

  typedef enum logic {
    OP_FRAME_START = 1'b0,
    OP_FRAME_END   = 1'b1
  } frml_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PERIOD,
    ST_RING,
    ST_SUM,
    ST_DIVGO,
    ST_DIV,
    ST_OUT
  } frml_state_t;

endpackage

// File: rtl/frame_rate_meter_limiter_unit.sv
// frame_rate_meter_limiter_unit: top level, sequencer and state of the meter/limiter
// depends on frml_pkg, frml_ring and frml_div
//
//   channel | signals                       | payload
//   in      | in_valid, in_stall, in_data    | frml_in_t  (operation, timestamp_ms)
//   out     | out_valid, out_stall, out_data | frml_out_t (fps_q8, frame_time_ms, delay_ms)
//   cfg     | cfg_we, cfg_wdata              | frame_period_ms
//
// a frame start records its timestamp and gives no result
// a frame end runs through ST_PERIOD, ST_RING, ST_SUM, ST_DIVGO, ST_DIV and ST_OUT; the
// one-bit-per-cycle divider runs in ST_DIV, and the result then waits for out_stall low
// with every period in the ring zero the divider is skipped and ST_DIVGO goes straight to ST_OUT
// in_stall is high from the cycle after an end transaction until its result is taken
// synchronous reset clears the sequencer, times, counts and sum; the ring needs no clearing

module frame_rate_meter_limiter_unit
  import frml_pkg::*;
#(
  parameter int unsigned SAMPLES = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  frml_in_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output frml_out_t        out_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int unsigned POS_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int unsigned CNT_W = $clog2(SAMPLES + 1);
  localparam int unsigned SUM_W = PER_W + CNT_W;
  localparam int unsigned NUM_W = SCALE_W + CNT_W;
  localparam int unsigned CMP_W = NUM_W + FPS_W;

  frml_state_t state, state_next;

  logic [CFG_W-1:0] frame_period;
  logic [TS_W-1:0]  frame_start_time;
  logic [TS_W-1:0]  last_end_time;
  logic             seen_first_end;
  logic [TS_W-1:0]  ts;
  logic [POS_W-1:0] pos;
  logic [CNT_W-1:0] filled;
  logic [SUM_W-1:0] period_sum;
  logic [PER_W-1:0] period;
  logic [CFG_W-1:0] delay;
  logic [FPS_W-1:0] fps;

  logic             in_acc;
  logic             full;
  logic [TS_W-1:0]  end_diff;
  logic [TS_W-1:0]  elapsed;
  logic [PER_W-1:0] ring_rdata;
  logic             ring_rd;
  logic             ring_we;
  logic             div_start;
  logic             div_done;
  logic [NUM_W-1:0] div_quot;
  logic [NUM_W-1:0] numer;

  assign in_acc   = in_valid && !in_stall;
  assign full     = filled == CNT_W'(SAMPLES);
  assign end_diff = ts - last_end_time;
  assign elapsed  = ts - frame_start_time;
  assign numer    = NUM_W'(FPS_SCALE) * NUM_W'(filled);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && in_data.operation == OP_FRAME_END) begin
          state_next = ST_PERIOD;
        end
      end
      ST_PERIOD: state_next = ST_RING;
      ST_RING:   state_next = ST_SUM;
      ST_SUM:    state_next = ST_DIVGO;
      ST_DIVGO:  state_next = (period_sum == '0) ? ST_OUT : ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    ring_rd   = 1'b0;
    ring_we   = 1'b0;
    div_start = 1'b0;
    unique case (state)
      ST_IDLE:   in_stall  = 1'b0;
      ST_PERIOD: ring_rd   = 1'b1;
      ST_RING:   ;
      ST_SUM:    ring_we   = 1'b1;
      ST_DIVGO:  div_start = period_sum != '0;
      ST_DIV:    ;
      ST_OUT:    out_valid = 1'b1;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      frame_period     <= FRAME_PERIOD_RST;
      frame_start_time <= '0;
      last_end_time    <= '0;
      seen_first_end   <= 1'b0;
      pos              <= '0;
      filled           <= '0;
      period_sum       <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        frame_period <= cfg_wdata;
      end
      if (in_acc && in_data.operation == OP_FRAME_START) begin
        frame_start_time <= in_data.timestamp_ms;
      end
      if (state == ST_PERIOD) begin
        last_end_time  <= ts;
        seen_first_end <= 1'b1;
      end
      if (state == ST_RING && full) begin
        period_sum <= period_sum - SUM_W'(ring_rdata);
      end
      if (state == ST_SUM) begin
        period_sum <= period_sum + SUM_W'(period);
        pos        <= (pos == POS_W'(SAMPLES - 1)) ? '0 : pos + POS_W'(1);
        if (!full) begin
          filled <= filled + CNT_W'(1);
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ts <= in_data.timestamp_ms;
    end
    if (state == ST_PERIOD) begin
      if (!seen_first_end) begin
        period <= '0;
      end else if (end_diff > TS_W'(PERIOD_SAT)) begin
        period <= PERIOD_SAT;
      end else begin
        period <= end_diff[PER_W-1:0];
      end
    end
    if (state == ST_RING) begin
      delay <= (TS_W'(frame_period) > elapsed) ? frame_period - elapsed[CFG_W-1:0] : '0;
    end
    if (state == ST_DIVGO && period_sum == '0) begin
      fps <= '0;
    end
    if (state == ST_DIV && div_done) begin
      // rate only overflows the field with a deep ring and tiny periods
      fps <= (CMP_W'(div_quot) > CMP_W'(FPS_MAX)) ? FPS_MAX : div_quot[FPS_W-1:0];
    end
  end

  assign out_data.fps_q8        = fps;
  assign out_data.frame_time_ms = period;
  assign out_data.delay_ms      = delay;

  frml_ring #(
    .DEPTH  (SAMPLES),
    .ADDR_W (POS_W)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (pos),
    .wdata (period),
    .rd_en (ring_rd),
    .raddr (pos),
    .rdata (ring_rdata)
  );

  frml_div #(
    .NUM_W (NUM_W),
    .DEN_W (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (numer),
    .divisor  (period_sum),
    .done     (div_done),
    .quotient (div_quot)
  );

endmodule

// File: rtl/frml_ring.sv
// frml_ring: ring of recent frame periods, one write and one registered read port
// depends on frml_pkg for the period width

module frml_ring
  import frml_pkg::*;
#(
  parameter int unsigned DEPTH  = 10,
  parameter int unsigned ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [PER_W-1:0]  wdata,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] raddr,
  output logic [PER_W-1:0]  rdata
);

  logic [PER_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/frml_div.sv
// frml_div: restoring divider, one quotient bit per cycle
// depends on frml_pkg; used by the top level for the averaged rate

module frml_div
  import frml_pkg::*;
#(
  parameter int unsigned NUM_W = 22,
  parameter int unsigned DEN_W = 20
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] nq;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign trial    = {rem, nq[NUM_W-1]};
  assign diff     = trial - {1'b0, den};
  assign ge       = trial >= {1'b0, den};
  assign quotient = nq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nq  <= dividend;
      den <= divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      nq  <= {nq[NUM_W-2:0], ge};
    end
  end

endmodule

// File: rtl/frml_checker.sv
// frml_checker: port-level assertions for the frame rate meter and limiter
// depends on frml_pkg; bound to frame_rate_meter_limiter_unit at the end of this file

module frml_checker
  import frml_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input frml_in_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input frml_out_t out_data
);

  // a held result does not change
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // no new transaction is taken while a result waits
  a_busy_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while result pending");

  // a frame end keeps the block busy in the next cycle
  a_end_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.operation == OP_FRAME_END |=> in_stall)
    else $error("frame end did not start the sequencer");

  // a frame start gives no result
  a_start_quiet: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.operation == OP_FRAME_START && !out_valid
    |=> !out_valid)
    else $error("frame start produced a result");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind frame_rate_meter_limiter_unit frml_checker u_frml_checker (.*);
